// File: src/fv3d_pkg.sv
package fv3d_pkg;

    // One input beat: q minus p geometry and both particles' squared weights
    typedef struct packed {
        logic signed [31:0] rel_x;
        logic signed [31:0] rel_y;
        logic signed [31:0] rel_z;
        logic signed [31:0] rel_vx;
        logic signed [31:0] rel_vy;
        logic signed [31:0] rel_vz;
        logic [30:0]        weight_p;
        logic [30:0]        weight_q;
        logic [30:0]        weight_p_before;
        logic [30:0]        weight_q_before;
    } fv3d_in_t;

    // One result beat
    typedef struct packed {
        logic signed [31:0] face_vx;
        logic signed [31:0] face_vy;
        logic signed [31:0] face_vz;
        logic               coincident;
    } fv3d_out_t;

    localparam int unsigned STEP_W      = 31;
    localparam logic [30:0] STEP_RESET  = 31'd65536;
    localparam logic [31:0] SAT_POS     = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG     = 32'h8000_0000;
    localparam int unsigned QUOT_BITS   = 32;

endpackage

// File: src/face_velocity_3d_core.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_data  (fv3d_in_t)
// out       output     out_valid / out_ready  out_data (fv3d_out_t)
// cfg       input      cfg_valid / cfg_ready  cfg_data (previous step, 31 bits)
//
// One beat enters per cycle while a stalled output does not back up the pipe.
// The pipe has nine arithmetic stages (32x32 multiplier banks and 128-bit
// adders), a 32-stage restoring divider, one quotient bit per stage, and an output stage.
// rst_n clears all valid bits and sets the step register to 1.0.
// A stalled output holds only the stages that are full; bubbles still close up.
module face_velocity_3d_core
    import fv3d_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fv3d_in_t            in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fv3d_out_t           out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [STEP_W-1:0]   cfg_data
);

    localparam int unsigned NUM_STAGES = 10 + QUOT_BITS;
    localparam int unsigned LAST       = NUM_STAGES - 1;

    typedef struct packed {
        logic [2:0][31:0]   rm;
        logic [2:0]         rneg;
        logic [2:0][31:0]   vm;
        logic [2:0]         vneg;
        logic signed [31:0] dw;
        logic [31:0]        em;
        logic               eneg;
        logic [30:0]        t;
        logic               coin;
    } s1_t;

    typedef struct packed {
        logic [2:0][63:0]   sq;
        logic [2:0][62:0]   mt;
        logic [2:0][63:0]   er;
        logic [2:0]         erneg;
        logic [2:0]         vneg;
        logic signed [31:0] dw;
        logic [30:0]        t;
        logic               coin;
    } s2_t;

    typedef struct packed {
        logic [63:0]        d2;
        logic [2:0][62:0]   mt;
        logic [2:0][63:0]   er;
        logic [2:0]         erneg;
        logic [2:0]         vneg;
        logic signed [31:0] dw;
        logic [30:0]        t;
        logic               coin;
    } s3_t;

    typedef struct packed {
        logic [63:0]        am;
        logic               aneg;
        logic [62:0]        dlo;
        logic [62:0]        dhi;
        logic [2:0][62:0]   mt;
        logic [2:0][63:0]   er;
        logic [2:0]         erneg;
        logic [2:0]         vneg;
        logic               coin;
    } s4_t;

    typedef struct packed {
        logic [2:0][3:0][63:0] pp;
        logic [2:0]            pneg;
        logic [95:0]           den;
        logic [2:0][63:0]      er;
        logic [2:0]            erneg;
        logic                  coin;
    } s5_t;

    typedef struct packed {
        logic [2:0][127:0]  pm;
        logic [2:0]         pneg;
        logic [95:0]        den;
        logic [2:0][63:0]   er;
        logic [2:0]         erneg;
        logic               coin;
    } s6_t;

    typedef struct packed {
        logic [2:0][127:0]  n;
        logic [95:0]        den;
        logic               coin;
    } s7_t;

    typedef struct packed {
        logic [2:0][127:0]  nm;
        logic [2:0]         nneg;
        logic [95:0]        den;
        logic               coin;
    } s8_t;

    typedef struct packed {
        logic [2:0][127:0]  rem;
        logic [2:0][31:0]   q;
        logic [2:0]         nneg;
        logic [2:0]         sat;
        logic [95:0]        den;
        logic               coin;
    } div_t;

    logic [STEP_W-1:0]      step_reg;
    logic [NUM_STAGES-1:0]  v_reg;
    logic [NUM_STAGES-1:0]  en;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;
    s5_t s5_reg, s5_next;
    s6_t s6_reg, s6_next;
    s7_t s7_reg, s7_next;
    s8_t s8_reg, s8_next;
    div_t      dv_reg [0:QUOT_BITS];
    div_t      dv0_next;
    fv3d_out_t out_reg, out_next;

    // Step register: written whenever a config beat arrives
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            step_reg <= cfg_data;
        end
    end

    // Stage enables: a stage advances when empty or when its successor advances
    always_comb
    begin
        en[LAST] = !v_reg[LAST] || out_ready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[LAST];
    assign out_data  = out_reg;

    // Advance valid bits along with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Stage 1: magnitudes, weight differences, step
    always_comb
    begin
        logic [2:0][31:0]   rr;
        logic [2:0][31:0]   vv;
        logic signed [31:0] dp;
        logic signed [31:0] dq;
        logic signed [32:0] e;
        rr = {in_data.rel_z, in_data.rel_y, in_data.rel_x};
        vv = {in_data.rel_vz, in_data.rel_vy, in_data.rel_vx};
        for (int k = 0; k < 3; k++)
        begin
            s1_next.rneg[k] = rr[k][31];
            s1_next.rm[k]   = rr[k][31] ? (32'd0 - rr[k]) : rr[k];
            s1_next.vneg[k] = vv[k][31];
            s1_next.vm[k]   = vv[k][31] ? (32'd0 - vv[k]) : vv[k];
        end
        s1_next.dw = $signed({1'b0, in_data.weight_p}) - $signed({1'b0, in_data.weight_q});
        dp = $signed({1'b0, in_data.weight_p}) - $signed({1'b0, in_data.weight_p_before});
        dq = $signed({1'b0, in_data.weight_q}) - $signed({1'b0, in_data.weight_q_before});
        e  = 33'(dp) - 33'(dq);
        s1_next.eneg = e[32];
        s1_next.em   = e[32] ? 32'(-e) : e[31:0];
        s1_next.t    = (step_reg == '0) ? 31'd1 : step_reg;
        s1_next.coin = (rr == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_reg <= s1_next;
        end
    end

    // Stage 2: squares, velocity times step, weight change times position
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s2_next.sq[k]    = 64'(s1_reg.rm[k]) * 64'(s1_reg.rm[k]);
            s2_next.mt[k]    = 63'(s1_reg.vm[k]) * 63'(s1_reg.t);
            s2_next.er[k]    = 64'(s1_reg.em) * 64'(s1_reg.rm[k]);
            s2_next.erneg[k] = s1_reg.eneg ^ s1_reg.rneg[k];
        end
        s2_next.vneg = s1_reg.vneg;
        s2_next.dw   = s1_reg.dw;
        s2_next.t    = s1_reg.t;
        s2_next.coin = s1_reg.coin;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_reg <= s2_next;
        end
    end

    // Stage 3: squared distance
    always_comb
    begin
        s3_next.d2    = s2_reg.sq[0] + s2_reg.sq[1] + s2_reg.sq[2];
        s3_next.mt    = s2_reg.mt;
        s3_next.er    = s2_reg.er;
        s3_next.erneg = s2_reg.erneg;
        s3_next.vneg  = s2_reg.vneg;
        s3_next.dw    = s2_reg.dw;
        s3_next.t     = s2_reg.t;
        s3_next.coin  = s2_reg.coin;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_reg <= s3_next;
        end
    end

    // Stage 4: A = d2 - dw * 2^F, denominator partial products
    always_comb
    begin
        logic signed [65:0] a;
        a = $signed({2'b00, s3_reg.d2}) - (66'(s3_reg.dw) <<< FRAC_BITS);
        s4_next.aneg  = a[65];
        s4_next.am    = a[65] ? 64'(-a) : a[63:0];
        s4_next.dlo   = 63'(s3_reg.d2[31:0]) * 63'(s3_reg.t);
        s4_next.dhi   = 63'(s3_reg.d2[63:32]) * 63'(s3_reg.t);
        s4_next.mt    = s3_reg.mt;
        s4_next.er    = s3_reg.er;
        s4_next.erneg = s3_reg.erneg;
        s4_next.vneg  = s3_reg.vneg;
        s4_next.coin  = s3_reg.coin;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_reg <= s4_next;
        end
    end

    // Stage 5: partial products of (v*t)*A, denominator 2*d2*t
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s5_next.pp[k][0] = 64'(s4_reg.mt[k][31:0]) * 64'(s4_reg.am[31:0]);
            s5_next.pp[k][1] = 64'(s4_reg.mt[k][31:0]) * 64'(s4_reg.am[63:32]);
            s5_next.pp[k][2] = 64'(s4_reg.mt[k][62:32]) * 64'(s4_reg.am[31:0]);
            s5_next.pp[k][3] = 64'(s4_reg.mt[k][62:32]) * 64'(s4_reg.am[63:32]);
            s5_next.pneg[k]  = s4_reg.vneg[k] ^ s4_reg.aneg;
        end
        s5_next.den   = ((96'(s4_reg.dhi) << 32) + 96'(s4_reg.dlo)) << 1;
        s5_next.er    = s4_reg.er;
        s5_next.erneg = s4_reg.erneg;
        s5_next.coin  = s4_reg.coin;
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s5_reg <= s5_next;
        end
    end

    // Stage 6: sum partial products
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s6_next.pm[k] = 128'(s5_reg.pp[k][0])
                          + (128'(s5_reg.pp[k][1]) << 32)
                          + (128'(s5_reg.pp[k][2]) << 32)
                          + (128'(s5_reg.pp[k][3]) << 64);
        end
        s6_next.pneg  = s5_reg.pneg;
        s6_next.den   = s5_reg.den;
        s6_next.er    = s5_reg.er;
        s6_next.erneg = s5_reg.erneg;
        s6_next.coin  = s5_reg.coin;
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s6_reg <= s6_next;
        end
    end

    // Stage 7: signed numerator
    always_comb
    begin
        logic [127:0] a;
        logic [127:0] b;
        for (int k = 0; k < 3; k++)
        begin
            a = s6_reg.pneg[k] ? (128'd0 - s6_reg.pm[k]) : s6_reg.pm[k];
            b = 128'(s6_reg.er[k]) << (2 * FRAC_BITS);
            if (s6_reg.erneg[k])
            begin
                b = 128'd0 - b;
            end
            s7_next.n[k] = a + b;
        end
        s7_next.den  = s6_reg.den;
        s7_next.coin = s6_reg.coin;
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s7_reg <= s7_next;
        end
    end

    // Stage 8: numerator magnitude
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s8_next.nneg[k] = s7_reg.n[k][127];
            s8_next.nm[k]   = s7_reg.n[k][127] ? (128'd0 - s7_reg.n[k]) : s7_reg.n[k];
        end
        s8_next.den  = s7_reg.den;
        s8_next.coin = s7_reg.coin;
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s8_reg <= s8_next;
        end
    end

    // Stage 9: flag quotients of 2^32 or more, seed divider
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dv0_next.sat[k] = s8_reg.nm[k] >= {s8_reg.den, 32'd0};
            dv0_next.rem[k] = s8_reg.nm[k];
            dv0_next.q[k]   = '0;
        end
        dv0_next.nneg = s8_reg.nneg;
        dv0_next.den  = s8_reg.den;
        dv0_next.coin = s8_reg.coin;
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            dv_reg[0] <= dv0_next;
        end
    end

    // Divider: one quotient bit per stage, most significant first
    for (genvar i = 0; i < QUOT_BITS; i++)
    begin : g_div
        localparam int unsigned SH = QUOT_BITS - 1 - i;
        div_t dv_next;

        always_comb
        begin
            logic [127:0] dsh;
            dv_next = dv_reg[i];
            dsh = {32'd0, dv_reg[i].den} << SH;
            for (int k = 0; k < 3; k++)
            begin
                if (dv_reg[i].rem[k] >= dsh)
                begin
                    dv_next.rem[k]   = dv_reg[i].rem[k] - dsh;
                    dv_next.q[k][SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[9 + i])
            begin
                dv_reg[i+1] <= dv_next;
            end
        end
    end

    // Output stage: sign, saturate, zero on coincident points
    always_comb
    begin
        logic [2:0][31:0] res;
        div_t d;
        d = dv_reg[QUOT_BITS];
        for (int k = 0; k < 3; k++)
        begin
            if (d.coin)
            begin
                res[k] = '0;
            end
            else if (d.nneg[k])
            begin
                res[k] = (d.sat[k] || d.q[k] > SAT_NEG) ? SAT_NEG : (32'd0 - d.q[k]);
            end
            else
            begin
                res[k] = (d.sat[k] || d.q[k][31]) ? SAT_POS : d.q[k];
            end
        end
        out_next.face_vx    = res[0];
        out_next.face_vy    = res[1];
        out_next.face_vz    = res[2];
        out_next.coincident = d.coin;
    end

    always_ff @(posedge clk)
    begin
        if (en[LAST])
        begin
            out_reg <= out_next;
        end
    end

endmodule

// File: sim/tb_face_velocity_3d_core.sv
module tb_face_velocity_3d_core;
    import fv3d_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LAT     = 42;
    localparam int DRAIN_CYCLES = PIPE_LAT + 20;
    localparam int RAND_ITEMS   = 1950;
    localparam int FRAC_SHIFT   = 16;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    fv3d_in_t            in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    fv3d_out_t           out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [STEP_W-1:0]   cfg_data = '0;

    // Step register as the block should hold it
    logic [30:0]         step_model = STEP_RESET;
    fv3d_out_t           pending_faces[$];
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  hold_off_cycles = 0;
    int                  mismatches = 0;
    int                  beats_in = 0;
    int                  beats_out = 0;
    int                  coincident_seen = 0;
    int                  saturated_seen = 0;
    int                  step_writes = 0;

    face_velocity_3d_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Compute the face velocity as one exact rational per component,
    // truncate toward zero, then saturate to 32 bits
    function automatic fv3d_out_t face_velocity(fv3d_in_t b, logic [30:0] dt_reg);
        logic signed [191:0] r[3];
        logic signed [191:0] v[3];
        logic signed [191:0] wp, wq, wpo, wqo, dw, e, d2, dt, den, num, mag, quo;
        logic signed [191:0] neg_lim;
        logic signed [191:0] pos_lim;
        logic [31:0]         res[3];
        fv3d_out_t           o;
        neg_lim = 192'sh8000_0000;
        pos_lim = 192'sh7FFF_FFFF;
        r[0] = b.rel_x;
        r[1] = b.rel_y;
        r[2] = b.rel_z;
        v[0] = b.rel_vx;
        v[1] = b.rel_vy;
        v[2] = b.rel_vz;
        wp  = b.weight_p;
        wq  = b.weight_q;
        wpo = b.weight_p_before;
        wqo = b.weight_q_before;
        d2 = r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
        o = '0;
        if (d2 == 0)
        begin
            o.coincident = 1'b1;
            return o;
        end
        dt  = (dt_reg == 0) ? 192'sd1 : dt_reg;
        dw  = wp - wq;
        e   = (wp - wpo) - (wq - wqo);
        den = (d2 * dt) <<< 1;
        for (int k = 0; k < 3; k++)
        begin
            num = v[k] * d2 * dt - ((v[k] * dw * dt) <<< FRAC_SHIFT)
                + ((e * r[k]) <<< (2 * FRAC_SHIFT));
            mag = (num < 0) ? -num : num;
            quo = mag / den;
            if (num < 0)
                res[k] = (quo > neg_lim) ? SAT_NEG : (32'd0 - quo[31:0]);
            else
                res[k] = (quo > pos_lim) ? SAT_POS : quo[31:0];
        end
        o.face_vx = res[0];
        o.face_vy = res[1];
        o.face_vz = res[2];
        return o;
    endfunction

    // Check each result beat against the oldest expected face
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            beats_out++;
            if (pending_faces.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result beat with nothing expected: %h", out_data);
            end
            else
            begin
                fv3d_out_t want;
                want = pending_faces.pop_front();
                if (want.coincident)
                    coincident_seen++;
                if (want.face_vx == SAT_POS || want.face_vx == SAT_NEG)
                    saturated_seen++;
                if (out_data.face_vx !== want.face_vx || out_data.face_vy !== want.face_vy ||
                    out_data.face_vz !== want.face_vz ||
                    out_data.coincident !== want.coincident)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: beat %0d expected vx=%h vy=%h vz=%h c=%b",
                                  " got vx=%h vy=%h vz=%h c=%b"},
                                 beats_out, want.face_vx, want.face_vy, want.face_vz,
                                 want.coincident, out_data.face_vx, out_data.face_vy,
                                 out_data.face_vz, out_data.coincident);
                end
            end
        end
    end

    // Drive the result ready: long hold-off when asked, else random stalls
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one beat, hold it until accepted, record its expected face
    task automatic send_pair(fv3d_in_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (!in_ready);
        pending_faces.push_back(face_velocity(b, step_model));
        beats_in++;
        @(negedge clk);
    endtask

    // Wait until every expected face has come back, then let the pipe settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_faces.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_step(logic [30:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        step_model = val;
        step_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random operand: full range, a narrowed magnitude to stay out of saturation, or near the extremes
    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(3))
            0: return w;
            1: return $signed(w) >>> $urandom_range(8, 20);
            2: return $signed(w) >>> $urandom_range(20, 30);
            default: return ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000) ^ (w & 32'hF);
        endcase
    endfunction

    function automatic logic [30:0] rand_weight();
        logic [30:0] w;
        w = 31'($urandom());
        return $urandom_range(1) ? w : (w >> $urandom_range(8, 28));
    endfunction

    function automatic fv3d_in_t rand_pair();
        fv3d_in_t b;
        b.rel_x  = rand_word();
        b.rel_y  = rand_word();
        b.rel_z  = rand_word();
        b.rel_vx = rand_word();
        b.rel_vy = rand_word();
        b.rel_vz = rand_word();
        b.weight_p        = rand_weight();
        b.weight_q        = rand_weight();
        b.weight_p_before = rand_weight();
        b.weight_q_before = rand_weight();
        // Drop the position now and then to hit coincident points
        if ($urandom_range(19) == 0)
            {b.rel_x, b.rel_y, b.rel_z} = '0;
        return b;
    endfunction

    // Extremes, coincident points, saturation both ways
    task automatic test_directed();
        fv3d_in_t b;
        b = '0;
        send_pair(b);
        b.rel_vx = 32'h7FFF_FFFF;
        b.weight_p = '1;
        send_pair(b);
        b = '0;
        b.rel_x = 32'h0001_0000;
        b.rel_vx = 32'h0001_0000;
        b.rel_vy = 32'hFFFF_0000;
        send_pair(b);
        b.rel_x = 32'h8000_0000;
        b.rel_y = 32'h8000_0000;
        b.rel_z = 32'h8000_0000;
        b.rel_vx = 32'h8000_0000;
        b.rel_vy = 32'h8000_0000;
        b.rel_vz = 32'h8000_0000;
        send_pair(b);
        b.rel_x = 32'h7FFF_FFFF;
        b.rel_y = 32'h7FFF_FFFF;
        b.rel_z = 32'h7FFF_FFFF;
        b.rel_vx = 32'h7FFF_FFFF;
        b.rel_vy = 32'h7FFF_FFFF;
        b.rel_vz = 32'h7FFF_FFFF;
        b.weight_p = '1;
        b.weight_q = '1;
        b.weight_p_before = '1;
        b.weight_q_before = '1;
        send_pair(b);
        // Tiny distance, huge weight gap: saturate both signs
        b = '0;
        b.rel_z = 32'h0000_0001;
        b.rel_vz = 32'h0001_0000;
        b.weight_p = '1;
        send_pair(b);
        b.rel_vz = 32'hFFFF_0000;
        send_pair(b);
        b = '0;
        b.rel_y = 32'hFFFF_FFFF;
        b.weight_p = '1;
        b.weight_q_before = '1;
        send_pair(b);
        b.weight_p = '0;
        b.weight_q = '1;
        b.weight_p_before = '1;
        b.weight_q_before = '0;
        send_pair(b);
        b = '0;
        b.rel_x = 32'h0002_0000;
        b.rel_y = 32'hFFFE_0000;
        b.rel_z = 32'h0001_8000;
        b.rel_vx = 32'h0000_8000;
        b.rel_vy = 32'hFFFF_8000;
        b.rel_vz = 32'h0003_0000;
        b.weight_p = 31'h0001_0000;
        b.weight_q = 31'h0000_8000;
        b.weight_p_before = 31'h0000_C000;
        b.weight_q_before = 31'h0001_0000;
        send_pair(b);
        drain();
    endtask

    task automatic test_random(int count);
        repeat (count) send_pair(rand_pair());
        drain();
    endtask

    // Hold the result side off long enough for the pipe to fill and push back
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_cycles = 300;
        repeat (200) send_pair(rand_pair());
        drain();
    endtask

    task automatic test_step_settings();
        logic [30:0] steps[5];
        steps[0] = 31'd1;
        steps[1] = 31'h7FFF_FFFF;
        steps[2] = 31'd32768;
        steps[3] = 31'($urandom());
        steps[4] = STEP_RESET;
        foreach (steps[i])
        begin
            write_step(steps[i]);
            test_directed();
            test_random(40);
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("FAIL face_velocity_3d_core");
        $finish;
    end

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        send_idle_pct = 36;
        recv_idle_pct = 56;
        test_random(RAND_ITEMS * 3 / 10);
        send_idle_pct = 56;
        recv_idle_pct = 36;
        test_random(RAND_ITEMS * 3 / 10);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(RAND_ITEMS / 6);
        test_backpressure();
        test_step_settings();

        $display("Covered %0d pair beats in, %0d faces out, %0d step writes",
                 beats_in, beats_out, step_writes);
        $display("  %0d coincident pairs, %0d saturated x components, %0d mismatches",
                 coincident_seen, saturated_seen, mismatches);
        if (mismatches == 0 && pending_faces.size() == 0)
            $display("PASS face_velocity_3d_core");
        else
            $display("FAIL face_velocity_3d_core");
        $finish;
    end

endmodule
